### rtl/core/ehvf_pkg.sv
// Package with the shared types, codes and the side-ring lookup of the earliest-hit veto filter.
package ehvf_pkg;

    localparam int TIME_BITS = 32;
    localparam int TIME_W    = (TIME_BITS < 32) ? TIME_BITS : 32;

    // Strings at or above this number are in no ring and never give a top veto.
    localparam logic [6:0] LAST_ICE_STRING_END = 7'd79;

    localparam logic [0:0] CFG_IDX_SIDE = 1'b0;
    localparam logic [0:0] CFG_IDX_TOP  = 1'b1;

    localparam logic [1:0] SIDE_LAYERS_RST = 2'd1;
    localparam logic [5:0] TOP_LAYERS_RST  = 6'd5;

    localparam logic [2:0] REASON_KEPT     = 3'd0;
    localparam logic [2:0] REASON_EMPTY    = 3'd1;
    localparam logic [2:0] REASON_BAD_FIT  = 3'd2;
    localparam logic [2:0] REASON_TOP_VETO = 3'd3;
    localparam logic [2:0] REASON_SIDE     = 3'd4;

    localparam logic [1:0] RING_NONE = 2'd0;
    localparam logic [1:0] RING_1    = 2'd1;
    localparam logic [1:0] RING_2    = 2'd2;
    localparam logic [1:0] RING_3    = 2'd3;

    typedef struct packed {
        logic [6:0]         pulse_string;
        logic [5:0]         pulse_dom;
        logic signed [31:0] pulse_time;
        logic               last_pulse;
        logic               event_empty;
        logic               fit_ok;
    } t_pulse;

    typedef struct packed {
        logic       keep_event;
        logic [2:0] reject_reason;
        logic [6:0] lead_string;
    } t_result;

    typedef struct packed {
        logic [1:0] side_veto_layers;
        logic [5:0] top_veto_layers;
    } t_cfg;

    // Outer ring that a string belongs to, counted from the outside in.
    function automatic logic [1:0] side_ring(input logic [6:0] s);
        logic [1:0] ring;
        ring = RING_NONE;
        case (s) inside
            7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd13, 7'd14, 7'd21,
            7'd22, 7'd30, 7'd31, 7'd40, 7'd41, 7'd50, 7'd51, 7'd59, 7'd60,
            7'd67, 7'd68, 7'd72, 7'd73, 7'd74, 7'd75, 7'd76, 7'd77, 7'd78:
                ring = RING_1;
            7'd8, 7'd9, 7'd10, 7'd11, 7'd12, 7'd15, 7'd20, 7'd23, 7'd29,
            7'd32, 7'd39, 7'd42, 7'd49, 7'd52, 7'd58, 7'd61, 7'd64, 7'd65,
            7'd66, 7'd69, 7'd70, 7'd71:
                ring = RING_2;
            7'd16, 7'd17, 7'd18, 7'd19, 7'd24, 7'd28, 7'd33, 7'd38, 7'd43,
            7'd48, 7'd53, 7'd55, 7'd56, 7'd57, 7'd62, 7'd63:
                ring = RING_3;
            default:
                ring = RING_NONE;
        endcase
        return ring;
    endfunction

endpackage

### rtl/core/ehvf_cfg.sv
// Configuration registers of the earliest-hit veto filter.
module ehvf_cfg
    import ehvf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr,
    input  logic [0:0] i_index,
    input  logic [5:0] i_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                CFG_IDX_SIDE: n_cfg.side_veto_layers = i_data[1:0];
                CFG_IDX_TOP:  n_cfg.top_veto_layers  = i_data;
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.side_veto_layers <= SIDE_LAYERS_RST;
            r_cfg.top_veto_layers  <= TOP_LAYERS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/ehvf_track.sv
// Event tracker: top-hit flag, running earliest pulse and the keep/reject decision.
module ehvf_track
    import ehvf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_go,
    input  t_pulse  i_pulse,
    input  t_cfg    i_cfg,
    output logic    o_has_result,
    output t_result o_result
);

    logic                     r_top_hit;
    logic                     r_seen;
    logic signed [TIME_W-1:0] r_time;
    logic [6:0]               r_string;

    logic                     n_top_hit;
    logic                     n_seen;
    logic signed [TIME_W-1:0] n_time;
    logic [6:0]               n_string;

    logic signed [TIME_W-1:0] pulse_key;
    logic                     top_hit;
    logic                     take;
    logic [6:0]               cand_string;
    logic [1:0]               ring;
    logic                     side_hit;
    logic [2:0]               reason;

    assign pulse_key   = $signed(i_pulse.pulse_time[TIME_W-1:0]);
    assign top_hit     = r_top_hit || ((i_pulse.pulse_dom <= i_cfg.top_veto_layers)
                                       && (i_pulse.pulse_string < LAST_ICE_STRING_END));
    // Strict compare keeps the first pulse on a tie.
    assign take        = !r_seen || (pulse_key < r_time);
    assign cand_string = take ? i_pulse.pulse_string : r_string;
    assign ring        = side_ring(cand_string);
    assign side_hit    = (ring != RING_NONE) && (ring <= i_cfg.side_veto_layers);

    always_comb begin
        if (i_pulse.event_empty) begin
            reason = REASON_EMPTY;
        end else if (!i_pulse.fit_ok) begin
            reason = REASON_BAD_FIT;
        end else if (top_hit) begin
            reason = REASON_TOP_VETO;
        end else if (side_hit) begin
            reason = REASON_SIDE;
        end else begin
            reason = REASON_KEPT;
        end
    end

    assign o_has_result           = i_pulse.event_empty || i_pulse.last_pulse;
    assign o_result.keep_event    = (reason == REASON_KEPT);
    assign o_result.reject_reason = reason;
    assign o_result.lead_string   = i_pulse.event_empty ? 7'd0 : cand_string;

    always_comb begin
        n_top_hit = r_top_hit;
        n_seen    = r_seen;
        n_time    = r_time;
        n_string  = r_string;
        if (i_go) begin
            if (o_has_result) begin
                n_top_hit = 1'b0;
                n_seen    = 1'b0;
                n_time    = {1'b0, {(TIME_W-1){1'b1}}};
                n_string  = 7'd0;
            end else begin
                n_top_hit = top_hit;
                n_seen    = 1'b1;
                if (take) begin
                    n_time   = pulse_key;
                    n_string = i_pulse.pulse_string;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_hit <= 1'b0;
            r_seen    <= 1'b0;
            r_time    <= {1'b0, {(TIME_W-1){1'b1}}};
            r_string  <= 7'd0;
        end else begin
            r_top_hit <= n_top_hit;
            r_seen    <= n_seen;
            r_time    <= n_time;
            r_string  <= n_string;
        end
    end

endmodule

### rtl/core/earliest_hit_veto_filter.sv
// Top level of the earliest-hit veto filter: input register, event tracker and result register.
// A decision passes the input register and then the result register; a final pulse waits
// in the input register while the result register holds a decision that is not taken.
// The block takes one pulse per cycle while no final pulse waits for the result register.
// Reset clears the handshake state and the event state and loads the register defaults
// (side_veto_layers 1, top_veto_layers 5); payload registers are not reset.
module earliest_hit_veto_filter
    import ehvf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Pulse channel.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_pulse     i_in_data,
    // Decision channel.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_result    o_out_data,
    // Configuration write channel.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_index,
    input  logic [5:0] i_cfg_data
);

    // Input register: holds one pulse until the tracker can consume it.
    logic    r_s1_valid;
    t_pulse  r_s1_data;
    // Result register: holds one decision until the consumer takes it.
    logic    r_out_valid;
    t_result r_out_data;

    t_cfg    cfg;
    logic    has_result;
    t_result result;
    logic    out_free;
    logic    s1_go;
    logic    in_xfer;

    // Config port always ready; the user must write only while the block is idle, unchecked.
    assign o_cfg_ready = 1'b1;

    ehvf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ehvf_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (s1_go),
        .i_pulse      (r_s1_data),
        .i_cfg        (cfg),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // The result register is free when empty or when its decision is taken this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    // A pulse that produces no decision never waits; a final pulse waits for the
    // result register.
    assign s1_go    = r_s1_valid && (!has_result || out_free);
    // The input register takes a new pulse whenever it is empty or drains this cycle, so a waiting
    // decision blocks the next pulse only while the pulse in the input register ends an event.
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && has_result) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A shown decision keeps the event exactly when its reason says kept.
    a_keep_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.keep_event == (o_out_data.reject_reason == REASON_KEPT)))
        else $error("keep flag disagrees with reject reason");

    // Only the defined reason codes ever leave the block.
    a_reason_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.reject_reason <= REASON_SIDE))
        else $error("undefined reject reason");

    // The pulse channel is stalled only while the input register holds a pulse.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with an empty input register");

    // A decision loaded into the result register comes from a pulse that ended an event.
    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_go && !r_s1_data.last_pulse && !r_s1_data.event_empty)
            |=> !(o_out_valid && !$past(o_out_valid)))
        else $error("decision produced by a pulse that does not end the event");

    // Reset leaves no decision on the output.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("decision valid after reset");

endmodule
